/* rtl/pstt_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// pstt_pkg
// Shared types and constants of the pooled two-sample t statistic core.
// ---------------------------------------------------------------------------
package pstt_pkg;

	// Default parameter values.
	localparam int MAX_GROUP_SAMPLES_DEF = 256;
	localparam int SAMPLE_BITS_DEF       = 16;

	// Depth of the queue between the accumulator front and the math back end.
	localparam int QUEUE_DEPTH = 2;

	// Fraction bits of the Q16.16 result.
	localparam int FRAC_BITS = 16;

	// Result status codes.
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FEW      = 2'd1;
	localparam logic [1:0] ST_ZERO_VAR = 2'd2;
	localparam logic [1:0] ST_OVERFLOW = 2'd3;

	// One input word: a sample, its group and the end-of-gene flag.
	typedef struct packed {
		logic signed [15:0] sample;
		logic               group;
		logic               last;
	} in_word_t;

	// One result word.
	typedef struct packed {
		logic signed [31:0] t_value;
		logic [1:0]         status;
		logic [8:0]         degrees_of_freedom;
	} out_word_t;

	// Queue status seen by the front and the back.
	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

endpackage
`default_nettype wire

/* rtl/pooled_two_sample_t_statistic_core.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// pooled_two_sample_t_statistic_core
// Streams per-gene samples and gives the pooled-variance Student t value.
// ---------------------------------------------------------------------------
// Samples are taken one word per cycle, while the snapshot queue is not
// full, into per-group count, sum and sum-of-squares accumulators; the
// word flagged last queues a snapshot (two deep) and clears them. The back
// end works through one snapshot at a time on a single shift-add multiplier
// that consumes one multiplier bit per cycle: about a dozen products for the
// deviations, pooled variance and numerator, then a 32-step binary search
// whose every step is one 32x32 square, formed outside the multiplier, plus
// a product of up to 64 multiplier bits. A gene with too few samples or zero
// pooled variance skips the search. The front keeps taking samples until the
// queue is full.
module pooled_two_sample_t_statistic_core #(
	parameter int MAX_GROUP_SAMPLES = pstt_pkg::MAX_GROUP_SAMPLES_DEF,
	parameter int SAMPLE_BITS       = pstt_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 sample_valid,
	output logic                      sample_ready,
	input  wire pstt_pkg::in_word_t   sample_word,
	output logic                      result_valid,
	input  wire logic                 result_ready,
	output pstt_pkg::out_word_t       result_word
);
	localparam int CW    = $clog2(MAX_GROUP_SAMPLES + 1);
	localparam int SW    = SAMPLE_BITS + CW;
	localparam int QW    = 2 * SAMPLE_BITS + CW;
	localparam int SNAPW = 2 * CW + 2 * SW + 2 * QW + 1;

	logic                  push, pop;
	logic [SNAPW-1:0]      push_data, pop_data;
	pstt_pkg::queue_stat_t qstat;

	pstt_front #(
		.MAX_GROUP_SAMPLES (MAX_GROUP_SAMPLES),
		.SAMPLE_BITS       (SAMPLE_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample_word  (sample_word),
		.qstat        (qstat),
		.push         (push),
		.push_data    (push_data)
	);

	pstt_fifo #(.WIDTH(SNAPW)) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (push_data),
		.rd_en   (pop),
		.rd_data (pop_data),
		.stat    (qstat)
	);

	pstt_back #(
		.MAX_GROUP_SAMPLES (MAX_GROUP_SAMPLES),
		.SAMPLE_BITS       (SAMPLE_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.qstat        (qstat),
		.pop_data     (pop_data),
		.pop          (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_word  (result_word)
	);
endmodule
`default_nettype wire

/* rtl/pstt_fifo.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// pstt_fifo
// Small register queue carrying per-gene accumulator snapshots.
// ---------------------------------------------------------------------------
module pstt_fifo #(
	parameter int WIDTH = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	output logic [WIDTH-1:0]      rd_data,
	output pstt_pkg::queue_stat_t stat
);
	localparam int DEPTH = pstt_pkg::QUEUE_DEPTH;
	localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW  = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CNTW-1:0]  count_q;

	// Pointer that wraps at the queue depth.
	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
		logic [PW-1:0] r;
		if (p == PW'(DEPTH - 1)) r = '0;
		else r = p + PW'(1);
		return r;
	endfunction

	assign stat.full  = (count_q == CNTW'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign rd_data    = mem_q[rd_ptr_q];

	// Storage, written on push.
	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_ptr_q] <= wr_data;
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) wr_ptr_q <= next_ptr(wr_ptr_q);
			if (rd_en) rd_ptr_q <= next_ptr(rd_ptr_q);
			if (wr_en && !rd_en) count_q <= count_q + CNTW'(1);
			else if (rd_en && !wr_en) count_q <= count_q - CNTW'(1);
		end
	end
endmodule
`default_nettype wire

/* rtl/pstt_front.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// pstt_front
// Per-group count, sum and sum-of-squares accumulators; one sample a cycle while the queue is not full.
// ---------------------------------------------------------------------------
module pstt_front #(
	parameter int MAX_GROUP_SAMPLES = pstt_pkg::MAX_GROUP_SAMPLES_DEF,
	parameter int SAMPLE_BITS       = pstt_pkg::SAMPLE_BITS_DEF,
	localparam int CW    = $clog2(MAX_GROUP_SAMPLES + 1),
	localparam int SW    = SAMPLE_BITS + CW,
	localparam int QW    = 2 * SAMPLE_BITS + CW,
	localparam int SNAPW = 2 * CW + 2 * SW + 2 * QW + 1
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    sample_valid,
	output logic                         sample_ready,
	input  wire pstt_pkg::in_word_t      sample_word,
	input  wire pstt_pkg::queue_stat_t   qstat,
	output logic                         push,
	output logic [SNAPW-1:0]             push_data
);
	typedef struct packed {
		logic [CW-1:0]        na;
		logic [CW-1:0]        nb;
		logic signed [SW-1:0] sa;
		logic signed [SW-1:0] sb;
		logic [QW-1:0]        qa;
		logic [QW-1:0]        qb;
		logic                 ovf;
	} snap_t;

	logic [CW-1:0]                na_q, nb_q;
	logic signed [SW-1:0]         sa_q, sb_q;
	logic [QW-1:0]                qa_q, qb_q;
	logic                         ovf_q;
	logic signed [SAMPLE_BITS-1:0] x;
	logic signed [2*SAMPLE_BITS-1:0] sq;
	logic                         fire;
	logic                         full_a, full_b;
	snap_t                        nxt;

	// Take the low sample bits as a signed value.
	if (SAMPLE_BITS <= 16) begin : g_narrow
		assign x = sample_word.sample[SAMPLE_BITS-1:0];
	end else begin : g_wide
		assign x = SAMPLE_BITS'(unsigned'(sample_word.sample));
	end

	assign sq           = x * x;
	assign sample_ready = !qstat.full;
	assign fire         = sample_valid && sample_ready;
	assign full_a       = (na_q == CW'(MAX_GROUP_SAMPLES));
	assign full_b       = (nb_q == CW'(MAX_GROUP_SAMPLES));

	// Accumulator values after this word; a sample for a full group is dropped.
	always_comb begin
		nxt.na  = na_q;
		nxt.nb  = nb_q;
		nxt.sa  = sa_q;
		nxt.sb  = sb_q;
		nxt.qa  = qa_q;
		nxt.qb  = qb_q;
		nxt.ovf = ovf_q;
		if (!sample_word.group) begin
			if (full_a) begin
				nxt.ovf = 1'b1;
			end else begin
				nxt.na = na_q + CW'(1);
				nxt.sa = sa_q + SW'(x);
				nxt.qa = qa_q + QW'(unsigned'(sq));
			end
		end else begin
			if (full_b) begin
				nxt.ovf = 1'b1;
			end else begin
				nxt.nb = nb_q + CW'(1);
				nxt.sb = sb_q + SW'(x);
				nxt.qb = qb_q + QW'(unsigned'(sq));
			end
		end
	end

	assign push      = fire && sample_word.last;
	assign push_data = nxt;

	// Accumulators; cleared when the gene's snapshot is queued.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			na_q  <= '0;
			nb_q  <= '0;
			sa_q  <= '0;
			sb_q  <= '0;
			qa_q  <= '0;
			qb_q  <= '0;
			ovf_q <= 1'b0;
		end else if (fire) begin
			if (sample_word.last) begin
				na_q  <= '0;
				nb_q  <= '0;
				sa_q  <= '0;
				sb_q  <= '0;
				qa_q  <= '0;
				qb_q  <= '0;
				ovf_q <= 1'b0;
			end else begin
				na_q  <= nxt.na;
				nb_q  <= nxt.nb;
				sa_q  <= nxt.sa;
				sb_q  <= nxt.sb;
				qa_q  <= nxt.qa;
				qb_q  <= nxt.qb;
				ovf_q <= nxt.ovf;
			end
		end
	end
endmodule
`default_nettype wire

/* rtl/pstt_mul.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// pstt_mul
// Shift-add multiplier: one bit of the b operand per cycle.
// ---------------------------------------------------------------------------
module pstt_mul #(
	parameter int W = 64
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [W-1:0] a,
	input  wire logic [W-1:0] b,
	output logic              done,
	output logic [W-1:0]      prod
);
	logic [W-1:0] a_q, b_q, p_q;
	logic         busy_q;

	// Finished once every set bit of b has been consumed.
	assign done = busy_q && (b_q == '0);
	assign prod = p_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (done) begin
			busy_q <= 1'b0;
		end
	end

	// Operand shifting and partial-product accumulation.
	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			p_q <= '0;
		end else if (busy_q && !done) begin
			if (b_q[0]) p_q <= p_q + a_q;
			a_q <= a_q << 1;
			b_q <= b_q >> 1;
		end
	end
endmodule
`default_nettype wire

/* rtl/pstt_back.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// pstt_back
// Per-gene math: deviations, pooled variance, and a binary search for the
// rounded Q16.16 t value, all but the search's square through one shared shift-add multiplier.
// ---------------------------------------------------------------------------
module pstt_back #(
	parameter int MAX_GROUP_SAMPLES = pstt_pkg::MAX_GROUP_SAMPLES_DEF,
	parameter int SAMPLE_BITS       = pstt_pkg::SAMPLE_BITS_DEF,
	localparam int CW    = $clog2(MAX_GROUP_SAMPLES + 1),
	localparam int SW    = SAMPLE_BITS + CW,
	localparam int QW    = 2 * SAMPLE_BITS + CW,
	localparam int SNAPW = 2 * CW + 2 * SW + 2 * QW + 1
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire pstt_pkg::queue_stat_t   qstat,
	input  wire logic [SNAPW-1:0]        pop_data,
	output logic                         pop,
	output logic                         result_valid,
	input  wire logic                    result_ready,
	output pstt_pkg::out_word_t          result_word
);
	localparam int DW   = SW + CW + 1;
	localparam int WW   = 2 * CW + QW + 2;
	localparam int DENW = WW + CW + 1;
	localparam int NUMW = 2 * DW + CW + 2 * pstt_pkg::FRAC_BITS + 4;
	localparam int BW   = ((NUMW > DENW + 65) ? NUMW : DENW + 65) + 1;
	localparam int SHIFT = 2 * pstt_pkg::FRAC_BITS + 2;

	typedef struct packed {
		logic [CW-1:0]        na;
		logic [CW-1:0]        nb;
		logic signed [SW-1:0] sa;
		logic signed [SW-1:0] sb;
		logic [QW-1:0]        qa;
		logic [QW-1:0]        qb;
		logic                 ovf;
	} snap_t;

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_CHK  = 5'd1;
	localparam logic [4:0] S_NQA  = 5'd2;
	localparam logic [4:0] S_SA2  = 5'd3;
	localparam logic [4:0] S_WA   = 5'd4;
	localparam logic [4:0] S_NQB  = 5'd5;
	localparam logic [4:0] S_SB2  = 5'd6;
	localparam logic [4:0] S_WB   = 5'd7;
	localparam logic [4:0] S_DA   = 5'd8;
	localparam logic [4:0] S_DB   = 5'd9;
	localparam logic [4:0] S_DEN  = 5'd10;
	localparam logic [4:0] S_D2   = 5'd11;
	localparam logic [4:0] S_NUM  = 5'd12;
	localparam logic [4:0] S_SQ   = 5'd13;
	localparam logic [4:0] S_SS   = 5'd14;
	localparam logic [4:0] S_CMP  = 5'd15;
	localparam logic [4:0] S_OUT  = 5'd16;

	logic [4:0]          state_q;
	snap_t               snap_q;
	logic [BW-1:0]       tmp_q, w_q, den_q, num_q, dmag_q;
	logic                dneg_q;
	logic [31:0]         lo_q, hi_q;
	logic [63:0]         odd2_q;
	pstt_pkg::out_word_t res_q;

	logic                m_start, m_done;
	logic [BW-1:0]       m_a, m_b, m_prod;
	logic [BW-1:0]       na_b, nb_b, nab_b, df_b, abs_sa, abs_sb, sgn_prod, dsig;
	logic signed [BW-1:0] sa_x, sb_x;
	logic [32:0]         mid_w;
	logic [31:0]         mid, odd;
	logic                few;

	pstt_mul #(.W(BW)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (m_start),
		.a      (m_a),
		.b      (m_b),
		.done   (m_done),
		.prod   (m_prod)
	);

	// Operands widened to the working width.
	assign na_b   = BW'(snap_q.na);
	assign nb_b   = BW'(snap_q.nb);
	assign nab_b  = na_b + nb_b;
	assign df_b   = nab_b - BW'(2);
	assign sa_x   = BW'(snap_q.sa);
	assign sb_x   = BW'(snap_q.sb);
	assign abs_sa = sa_x[BW-1] ? BW'(-sa_x) : BW'(sa_x);
	assign abs_sb = sb_x[BW-1] ? BW'(-sb_x) : BW'(sb_x);
	assign few    = (snap_q.na < CW'(2)) || (snap_q.nb < CW'(2));

	// Signed cross terms: SA*nB in tmp, minus SB*nA from the multiplier.
	assign sgn_prod = sb_x[BW-1] ? (~m_prod + BW'(1)) : m_prod;
	assign dsig     = tmp_q - sgn_prod;

	// Binary search midpoint and its odd bound 2*mid-1.
	assign mid_w = {1'b0, lo_q} + ((33'(hi_q) - 33'(lo_q) + 33'd1) >> 1);
	assign mid   = mid_w[31:0];
	assign odd   = {mid[30:0], 1'b0} - 32'd1;

	assign pop          = (state_q == S_IDLE) && !qstat.empty;
	assign result_valid = (state_q == S_OUT);
	assign result_word  = res_q;

	// Multiplier operand selection for each step.
	always_comb begin
		m_start = 1'b0;
		m_a     = '0;
		m_b     = '0;
		unique case (state_q)
			S_CHK: begin
				m_start = !few;
				m_a     = BW'(snap_q.qa);
				m_b     = na_b;
			end
			S_NQA: begin
				m_start = m_done;
				m_a     = abs_sa;
				m_b     = abs_sa;
			end
			S_SA2: begin
				m_start = m_done;
				m_a     = tmp_q - m_prod;
				m_b     = nb_b;
			end
			S_WA: begin
				m_start = m_done;
				m_a     = BW'(snap_q.qb);
				m_b     = nb_b;
			end
			S_NQB: begin
				m_start = m_done;
				m_a     = abs_sb;
				m_b     = abs_sb;
			end
			S_SB2: begin
				m_start = m_done;
				m_a     = tmp_q - m_prod;
				m_b     = na_b;
			end
			S_WB: begin
				m_start = m_done;
				m_a     = abs_sa;
				m_b     = nb_b;
			end
			S_DA: begin
				m_start = m_done;
				m_a     = abs_sb;
				m_b     = na_b;
			end
			S_DB: begin
				m_start = m_done && (w_q != '0);
				m_a     = w_q;
				m_b     = nab_b;
			end
			S_DEN: begin
				m_start = m_done;
				m_a     = dmag_q;
				m_b     = dmag_q;
			end
			S_D2: begin
				m_start = m_done;
				m_a     = m_prod;
				m_b     = df_b;
			end
			S_SS: begin
				m_start = 1'b1;
				m_a     = den_q;
				m_b     = BW'(odd2_q);
			end
			default: begin
				m_start = 1'b0;
			end
		endcase
	end

	// Sequencer control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: if (!qstat.empty) state_q <= S_CHK;
				S_CHK:  state_q <= few ? S_OUT : S_NQA;
				S_NQA:  if (m_done) state_q <= S_SA2;
				S_SA2:  if (m_done) state_q <= S_WA;
				S_WA:   if (m_done) state_q <= S_NQB;
				S_NQB:  if (m_done) state_q <= S_SB2;
				S_SB2:  if (m_done) state_q <= S_WB;
				S_WB:   if (m_done) state_q <= S_DA;
				S_DA:   if (m_done) state_q <= S_DB;
				S_DB:   if (m_done) state_q <= (w_q == '0) ? S_OUT : S_DEN;
				S_DEN:  if (m_done) state_q <= S_D2;
				S_D2:   if (m_done) state_q <= S_NUM;
				S_NUM:  if (m_done) state_q <= S_SQ;
				S_SQ:   state_q <= (lo_q < hi_q) ? S_SS : S_OUT;
				S_SS:   state_q <= S_CMP;
				S_CMP:  if (m_done) state_q <= S_SQ;
				S_OUT:  if (result_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Working registers and the result word.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (!qstat.empty) snap_q <= pop_data;
			end
			S_CHK: begin
				res_q.t_value            <= '0;
				res_q.status             <= pstt_pkg::ST_FEW;
				res_q.degrees_of_freedom <= few ? 9'd0 : df_b[8:0];
			end
			S_NQA: if (m_done) tmp_q <= m_prod;
			S_SA2: begin end
			S_WA:  if (m_done) w_q <= m_prod;
			S_NQB: if (m_done) tmp_q <= m_prod;
			S_SB2: begin end
			S_WB:  if (m_done) w_q <= w_q + m_prod;
			S_DA: begin
				if (m_done) tmp_q <= sa_x[BW-1] ? (~m_prod + BW'(1)) : m_prod;
			end
			S_DB: begin
				if (m_done) begin
					dneg_q <= dsig[BW-1];
					dmag_q <= dsig[BW-1] ? (~dsig + BW'(1)) : dsig;
					if (w_q == '0) begin
						res_q.status <= pstt_pkg::ST_ZERO_VAR;
						if (dsig == '0) res_q.t_value <= '0;
						else if (dsig[BW-1]) res_q.t_value <= 32'sh8000_0000;
						else res_q.t_value <= 32'sh7FFF_FFFF;
					end else begin
						res_q.status <= snap_q.ovf ? pstt_pkg::ST_OVERFLOW
							: pstt_pkg::ST_OK;
					end
				end
			end
			S_DEN: if (m_done) den_q <= m_prod;
			S_D2:  begin end
			S_NUM: begin
				if (m_done) begin
					num_q <= m_prod << SHIFT;
					lo_q  <= '0;
					hi_q  <= 32'h8000_0000;
				end
			end
			S_SQ: begin
				odd2_q <= odd * odd;
				if (lo_q >= hi_q) begin
					if (dneg_q) res_q.t_value <= -lo_q;
					else if (lo_q[31]) res_q.t_value <= 32'sh7FFF_FFFF;
					else res_q.t_value <= lo_q;
				end
			end
			S_SS: begin end
			S_CMP: begin
				if (m_done) begin
					if (m_prod <= num_q) lo_q <= mid;
					else hi_q <= mid - 32'd1;
				end
			end
			S_OUT: begin end
			default: begin end
		endcase
	end
endmodule
`default_nettype wire

/* rtl/pstt_checker.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// pstt_checker
// Port-level checks of the t statistic core, bound to the top level.
// ---------------------------------------------------------------------------
module pstt_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                sample_valid,
	input wire logic                sample_ready,
	input wire pstt_pkg::in_word_t  sample_word,
	input wire logic                result_valid,
	input wire logic                result_ready,
	input wire pstt_pkg::out_word_t result_word
);
	// A waiting sample word keeps its value until taken.
	a_sample_hold: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && !sample_ready |=> sample_valid && $stable(sample_word))
		else $error("sample word changed while stalled");

	// A waiting result word keeps its value until taken.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result_word))
		else $error("result word changed while stalled");

	// Too few samples gives a zero t value and zero degrees of freedom.
	a_few_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_word.status == pstt_pkg::ST_FEW |->
		result_word.t_value == '0 && result_word.degrees_of_freedom == '0)
		else $error("too-few result not zero");

	// Any other status comes from at least two samples in each group.
	a_dof_min: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_word.status != pstt_pkg::ST_FEW |->
		result_word.degrees_of_freedom >= 9'd2)
		else $error("degrees of freedom too small");

	// Zero pooled variance gives zero or a saturated t value.
	a_zero_var: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_word.status == pstt_pkg::ST_ZERO_VAR |->
		result_word.t_value == 32'sh0 || result_word.t_value == 32'sh7FFF_FFFF ||
		result_word.t_value == 32'sh8000_0000)
		else $error("zero-variance t value not saturated");
endmodule

bind pooled_two_sample_t_statistic_core pstt_checker u_pstt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.sample_valid (sample_valid),
	.sample_ready (sample_ready),
	.sample_word  (sample_word),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result_word  (result_word)
);
`default_nettype wire
